[rtl/core/rgblab_pkg.sv]
// ============================================================================
// RGB to CIELAB package
// Shared widths, matrix coefficients, output constants, the stage-enable
// struct and the cube-root table that is built at elaboration.
// ============================================================================
package rgblab_pkg;

    localparam int FRAC_BITS   = 22;
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int PIX_W       = 8;
    localparam int NUM_CH      = 3;
    localparam int COEF_W      = 20;
    localparam int PROD_W      = PIX_W + COEF_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int IDX_SHIFT   = 18;
    localparam int IDX_SCALE   = 1020;
    localparam int ROOT_W      = FRAC_BITS + 1;
    localparam int ACC_W       = FRAC_BITS + 12;
    localparam int OUT_W       = ACC_W - FRAC_BITS;

    // Linear segment of the table: entries up to LIN_LAST hold
    // 2^FRAC_BITS * (LIN_SLOPE * i + LIN_BASE) / LIN_DEN, rounded half up.
    localparam int          LIN_LAST  = 9;
    localparam longint      LIN_SLOPE = 24389;
    localparam longint      LIN_BASE  = 440640;
    localparam logic [127:0] LIN_DEN  = 128'd3194640;
    localparam logic [127:0] LIN_HALF = 128'd1597320;

    typedef logic [PIX_W-1:0]  t_pix;
    typedef logic [COEF_W-1:0] t_coef;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [ROOT_W-1:0] t_root;
    typedef t_root             t_root_rom [TABLE_DEPTH];

    // Matrix rows are X, Y, Z; columns are blue, green, red.
    localparam int ROW_X = 0;
    localparam int ROW_Y = 1;
    localparam int ROW_Z = 2;
    localparam int CH_BLUE  = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_RED   = 2;

    localparam t_coef COEF [NUM_CH][NUM_CH] = '{
        '{20'd199049, 20'd394494, 20'd455033},
        '{20'd75675,  20'd749900, 20'd223002},
        '{20'd915161, 20'd114795, 20'd18621}
    };

    localparam logic [SUM_W-1:0] IDX_ROUND = SUM_W'(1) << (IDX_SHIFT - 1);

    // Output arithmetic constants.
    localparam longint L_OFFSET_RAW = ((longint'(408) << FRAC_BITS) + 5) / 10;
    localparam logic signed [ACC_W-1:0] L_OFFSET   = ACC_W'(L_OFFSET_RAW);
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] L_SCALE    = ACC_W'(296);
    localparam logic signed [ACC_W-1:0] A_SCALE    = ACC_W'(500);
    localparam logic signed [ACC_W-1:0] B_SCALE    = ACC_W'(200);
    localparam logic signed [OUT_W:0]   AB_OFFSET  = (OUT_W + 1)'(128);

    // One enable per pipeline stage; a stage loads when its enable is high.
    typedef struct packed {
        logic prod;
        logic index;
        logic rom;
        logic scale;
        logic sat;
    } t_stage_en;

    // True when round(2^F * cbrt(idx / 1020)) is at least v.
    function automatic logic root_at_least(input logic [127:0] idx,
                                           input logic [127:0] v);
        logic [127:0] t;
        logic [127:0] lhs;
        logic [127:0] rhs;
        t   = (v << 1) - 128'd1;
        lhs = t * t * t * 128'(IDX_SCALE);
        rhs = idx << (3 * FRAC_BITS + 3);
        return lhs <= rhs;
    endfunction

    function automatic t_root root_entry(input int unsigned i);
        logic [127:0] v;
        logic [127:0] cand;
        logic [127:0] num;
        v = '0;
        if (i > LIN_LAST) begin
            // Largest v with the predicate true, built from the top bit down.
            for (int bit_pos = FRAC_BITS; bit_pos >= 0; bit_pos--) begin
                cand = v | (128'd1 << bit_pos);
                if (root_at_least(128'(i), cand)) begin
                    v = cand;
                end
            end
            return ROOT_W'(v);
        end else begin
            num = 128'(LIN_SLOPE * longint'(i) + LIN_BASE) << FRAC_BITS;
            return ROOT_W'((num + LIN_HALF) / LIN_DEN);
        end
    endfunction

    function automatic t_root_rom build_root_rom();
        t_root_rom rom;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            rom[i] = root_entry(i);
        end
        return rom;
    endfunction

    localparam t_root_rom ROOT_ROM = build_root_rom();

endpackage

[rtl/core/rgb_to_lab_pixel.sv]
// ============================================================================
// RGB to CIELAB pixel converter
// Five-stage pipeline that turns one 8-bit blue, green, red pixel into one
// 8-bit L, a, b pixel each clock while the output side does not stall.
// ============================================================================
// Each accepted pixel gives exactly one result. While the output side does
// not stall, the pipeline takes one pixel every clock. Its stages are a
// matrix product stage, an index rounding stage, a table read stage (three
// copies of the cube-root table, one per X, Y and Z index, so all three
// reads happen in the same cycle), a scaling stage and a saturation stage
// that is also the output register. Each stage carries a valid bit and
// loads whenever it is empty or the stage after it loads, so bubbles close
// up and a stalled output holds its result while earlier stages keep
// filling. Lightness is L scaled by 2.55; the two color axes carry an
// offset of 128; all three saturate to the range 0 to 255. There is no
// configuration and no state beyond the pipeline.
// ============================================================================
module rgb_to_lab_pixel
    import rgblab_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_pix_valid,
    output logic o_pix_ready,
    input  t_pix i_blue,
    input  t_pix i_green,
    input  t_pix i_red,
    output logic o_lab_valid,
    input  logic i_lab_ready,
    output t_pix o_lightness,
    output t_pix o_green_red_axis,
    output t_pix o_blue_yellow_axis
);

    t_stage_en stage_en;
    logic      r_v_prod;
    logic      r_v_index;
    logic      r_v_rom;
    logic      r_v_scale;
    logic      r_v_sat;
    t_idx      idx_x;
    t_idx      idx_y;
    t_idx      idx_z;
    t_root     root_x;
    t_root     root_y;
    t_root     root_z;

    // A stage may load when it is empty or when its contents move on.
    always_comb begin
        stage_en.sat   = !r_v_sat   || i_lab_ready;
        stage_en.scale = !r_v_scale || stage_en.sat;
        stage_en.rom   = !r_v_rom   || stage_en.scale;
        stage_en.index = !r_v_index || stage_en.rom;
        stage_en.prod  = !r_v_prod  || stage_en.index;
    end

    assign o_pix_ready = stage_en.prod;
    assign o_lab_valid = r_v_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_prod  <= 1'b0;
            r_v_index <= 1'b0;
            r_v_rom   <= 1'b0;
            r_v_scale <= 1'b0;
            r_v_sat   <= 1'b0;
        end else begin
            if (stage_en.prod) begin
                r_v_prod <= i_pix_valid;
            end
            if (stage_en.index) begin
                r_v_index <= r_v_prod;
            end
            if (stage_en.rom) begin
                r_v_rom <= r_v_index;
            end
            if (stage_en.scale) begin
                r_v_scale <= r_v_rom;
            end
            if (stage_en.sat) begin
                r_v_sat <= r_v_scale;
            end
        end
    end

    // Matrix products and index rounding.
    rgblab_matrix u_matrix (
        .i_clk   (i_clk),
        .i_en    (stage_en),
        .i_blue  (i_blue),
        .i_green (i_green),
        .i_red   (i_red),
        .o_idx_x (idx_x),
        .o_idx_y (idx_y),
        .o_idx_z (idx_z)
    );

    // One table copy per index keeps the read stage at one pixel a clock when nothing stalls.
    rgblab_root_rom u_rom_x (
        .i_clk  (i_clk),
        .i_en   (stage_en.rom),
        .i_addr (idx_x),
        .o_data (root_x)
    );

    rgblab_root_rom u_rom_y (
        .i_clk  (i_clk),
        .i_en   (stage_en.rom),
        .i_addr (idx_y),
        .o_data (root_y)
    );

    rgblab_root_rom u_rom_z (
        .i_clk  (i_clk),
        .i_en   (stage_en.rom),
        .i_addr (idx_z),
        .o_data (root_z)
    );

    // Scaling, rounding shift and saturation into the output register.
    rgblab_output u_output (
        .i_clk              (i_clk),
        .i_en               (stage_en),
        .i_root_x           (root_x),
        .i_root_y           (root_y),
        .i_root_z           (root_z),
        .o_lightness        (o_lightness),
        .o_green_red_axis   (o_green_red_axis),
        .o_blue_yellow_axis (o_blue_yellow_axis)
    );

`ifndef SYNTHESIS
    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_lab_valid)
        else $error("output valid after reset");

    a_accept_enters_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_valid && o_pix_ready |=> r_v_prod)
        else $error("accepted transaction did not enter the first stage");

    a_stall_holds_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v_sat && !i_lab_ready && r_v_scale |=> r_v_scale && r_v_sat)
        else $error("pixel lost while the output stalled");

    a_index_moves_to_rom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v_index && stage_en.rom |=> r_v_rom)
        else $error("index stage contents dropped before the table read");
`endif

endmodule

[rtl/core/rgblab_matrix.sv]
// ============================================================================
// RGB to CIELAB matrix stages
// Two pipeline stages: nine coefficient products, then the three rounded
// sums that become the X, Y and Z table indices.
// ============================================================================
module rgblab_matrix
    import rgblab_pkg::*;
(
    input  logic      i_clk,
    input  t_stage_en i_en,
    input  t_pix      i_blue,
    input  t_pix      i_green,
    input  t_pix      i_red,
    output t_idx      o_idx_x,
    output t_idx      o_idx_y,
    output t_idx      o_idx_z
);

    t_pix              pix    [NUM_CH];
    logic [PROD_W-1:0] r_prod [NUM_CH][NUM_CH];
    logic [SUM_W-1:0]  n_sum  [NUM_CH];
    t_idx              r_idx  [NUM_CH];

    always_comb begin
        pix[CH_BLUE]  = i_blue;
        pix[CH_GREEN] = i_green;
        pix[CH_RED]   = i_red;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.prod) begin
            for (int row = 0; row < NUM_CH; row++) begin
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    r_prod[row][ch] <= PROD_W'(pix[ch]) * PROD_W'(COEF[row][ch]);
                end
            end
        end
    end

    // The sum never exceeds 28 bits, so the index select equals the mask.
    always_comb begin
        for (int row = 0; row < NUM_CH; row++) begin
            n_sum[row] = SUM_W'(r_prod[row][CH_BLUE]) + SUM_W'(r_prod[row][CH_GREEN])
                       + SUM_W'(r_prod[row][CH_RED]) + IDX_ROUND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.index) begin
            for (int row = 0; row < NUM_CH; row++) begin
                r_idx[row] <= n_sum[row][IDX_SHIFT +: IDX_W];
            end
        end
    end

    assign o_idx_x = r_idx[ROW_X];
    assign o_idx_y = r_idx[ROW_Y];
    assign o_idx_z = r_idx[ROW_Z];

endmodule

[rtl/core/rgblab_root_rom.sv]
// ============================================================================
// RGB to CIELAB cube-root table
// Constant table of cube roots with a registered read port.
// ============================================================================
module rgblab_root_rom
    import rgblab_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_idx  i_addr,
    output t_root o_data
);

    t_root r_data;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= ROOT_ROM[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

[rtl/core/rgblab_output.sv]
// ============================================================================
// RGB to CIELAB output stages
// Scales the cube roots into L, a and b accumulators, then shifts, offsets
// and saturates them into the 8-bit result.
// ============================================================================
module rgblab_output
    import rgblab_pkg::*;
(
    input  logic      i_clk,
    input  t_stage_en i_en,
    input  t_root     i_root_x,
    input  t_root     i_root_y,
    input  t_root     i_root_z,
    output t_pix      o_lightness,
    output t_pix      o_green_red_axis,
    output t_pix      o_blue_yellow_axis
);

    logic signed [ACC_W-1:0] xs;
    logic signed [ACC_W-1:0] ys;
    logic signed [ACC_W-1:0] zs;
    logic signed [ACC_W-1:0] r_acc_l;
    logic signed [ACC_W-1:0] r_acc_a;
    logic signed [ACC_W-1:0] r_acc_b;
    logic signed [OUT_W-1:0] q_l;
    logic signed [OUT_W-1:0] q_a;
    logic signed [OUT_W-1:0] q_b;
    t_pix                    r_lightness;
    t_pix                    r_green_red_axis;
    t_pix                    r_blue_yellow_axis;

    function automatic t_pix sat8(input logic signed [OUT_W:0] v);
        priority if (v < 0) begin
            return '0;
        end else if (v > (OUT_W + 1)'(255)) begin
            return '1;
        end else begin
            return v[PIX_W-1:0];
        end
    endfunction

    assign xs = $signed(ACC_W'(i_root_x));
    assign ys = $signed(ACC_W'(i_root_y));
    assign zs = $signed(ACC_W'(i_root_z));

    always_ff @(posedge i_clk) begin
        if (i_en.scale) begin
            r_acc_l <= ys * L_SCALE - L_OFFSET + ROUND_HALF;
            r_acc_a <= (xs - ys) * A_SCALE + ROUND_HALF;
            r_acc_b <= (ys - zs) * B_SCALE + ROUND_HALF;
        end
    end

    // An arithmetic right shift is a floor division by 2^F.
    assign q_l = OUT_W'(r_acc_l >>> FRAC_BITS);
    assign q_a = OUT_W'(r_acc_a >>> FRAC_BITS);
    assign q_b = OUT_W'(r_acc_b >>> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (i_en.sat) begin
            r_lightness        <= sat8((OUT_W + 1)'(q_l));
            r_green_red_axis   <= sat8((OUT_W + 1)'(q_a) + AB_OFFSET);
            r_blue_yellow_axis <= sat8((OUT_W + 1)'(q_b) + AB_OFFSET);
        end
    end

    assign o_lightness        = r_lightness;
    assign o_green_red_axis   = r_green_red_axis;
    assign o_blue_yellow_axis = r_blue_yellow_axis;

endmodule
